// ===== hdl/sliding_window_peak_rate_macros.svh =====
// Assertion macros shared by the checker of the sliding window peak rate block.
`ifndef SLIDING_WINDOW_PEAK_RATE_MACROS_SVH
`define SLIDING_WINDOW_PEAK_RATE_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define SWPR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define SWPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SWPR_ASSERT_RESET(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/swpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package swpr_pkg;

  localparam int TIME_W      = 31;
  localparam int CNT_W       = 32;
  localparam int MEM_W       = TIME_W + CNT_W;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 160;
  localparam int FIFO_DEPTH_DEF = 256;

  localparam logic [TIME_W-1:0] WINDOW_RESET = TIME_W'(60);
  localparam logic [CNT_W-1:0]  CNT_MAX      = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } swpr_state_t;

endpackage

`default_nettype wire

// ===== hdl/swpr_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module swpr_ram
  import swpr_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = MEM_W
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/sliding_window_peak_rate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sliding window peak rate over a stream of log records.
// Input channel (in_*): one record per item; in_tuser says whether the record
// carries a timestamp, in_tdata holds the timestamp and the server-error flag.
// Output channel (out_*): exactly one result item per record, in order, with the
// window count, the running peak with its begin and end times, the error count
// and the overflow flag. cfg_we writes the window length; it resets to 60 s.
// Timestamps and record numbers live in one FIFO memory with a registered read.
// A timed record reaches the output register after reading the oldest entry, the
// compare and the finish step, with one more memory read for every entry that
// falls out of the window. The input reopens once the result is written, so the
// block takes no new record before the last one is through. A record without a
// timestamp goes straight to the finish step.
// Since every record pushes at most one entry, the dropped entries average under
// one per record.
// Reset empties the FIFO and clears all counters and the peak; the memory is
// not cleared, as entries are read only after they have been written.
// A stalled receiver holds the result in the output register; the block keeps
// working on the next item and waits in its last step until the register frees.

module sliding_window_peak_rate
  import swpr_pkg::*;
#(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration: window length in seconds.
  input  wire logic                  cfg_we,
  input  wire logic [TIME_W-1:0]     cfg_wdata,
  // Input channel.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // timestamp[30:0], server_error[31]
  input  wire logic                  in_tuser,   // has_time
  // Result channel.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // window_count[31:0], peak_count[63:32], peak_begin[94:64], peak_end[125:95],
  // error_count[157:126], overflow[158], zero[159]
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int OW = $clog2(FIFO_DEPTH + 1);

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
    return (p == AW'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  swpr_state_t           state_r, state_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic [OW-1:0]         occ_r, occ_nxt;
  logic [CNT_W-1:0]      rc_r, rc_nxt;
  logic [CNT_W-1:0]      best_cnt_r, best_cnt_nxt;
  logic [TIME_W-1:0]     best_begin_r, best_begin_nxt;
  logic [TIME_W-1:0]     best_end_r, best_end_nxt;
  logic [CNT_W-1:0]      err_r, err_nxt;
  logic [TIME_W-1:0]     win_r;
  logic [TIME_W-1:0]     ts_r, ts_nxt;
  logic                  srv_err_r, srv_err_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [TIME_W-1:0]     tail_time_r, tail_time_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                  mem_we;
  logic [AW-1:0]         mem_raddr;
  logic [MEM_W-1:0]      mem_rdata;
  logic [TIME_W-1:0]     rd_time;
  logic [CNT_W-1:0]      rd_num;
  logic signed [TIME_W+1:0] excess;
  logic [CNT_W:0]        span;

  swpr_ram #(
    .DEPTH (FIFO_DEPTH),
    .AW    (AW),
    .DW    (MEM_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (head_r),
    .wdata ({in_tdata[TIME_W-1:0], rc_r}),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_time = mem_rdata[MEM_W-1:CNT_W];
  assign rd_num  = mem_rdata[CNT_W-1:0];
  // Positive when the oldest entry lies more than the window before the new record.
  assign excess  = $signed({2'b00, ts_r}) - $signed({2'b00, rd_time})
                 - $signed({2'b00, win_r});
  assign span    = {1'b0, rc_r} - {1'b0, rd_num} + (CNT_W+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      occ_r        <= '0;
      rc_r         <= '0;
      best_cnt_r   <= '0;
      best_begin_r <= '0;
      best_end_r   <= '0;
      err_r        <= '0;
      win_r        <= WINDOW_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      occ_r        <= occ_nxt;
      rc_r         <= rc_nxt;
      best_cnt_r   <= best_cnt_nxt;
      best_begin_r <= best_begin_nxt;
      best_end_r   <= best_end_nxt;
      err_r        <= err_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        win_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ts_r        <= ts_nxt;
    srv_err_r   <= srv_err_nxt;
    ovf_r       <= ovf_nxt;
    tail_time_r <= tail_time_nxt;
    cnt_r       <= cnt_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    occ_nxt        = occ_r;
    rc_nxt         = rc_r;
    best_cnt_nxt   = best_cnt_r;
    best_begin_nxt = best_begin_r;
    best_end_nxt   = best_end_r;
    err_nxt        = err_r;
    ts_nxt         = ts_r;
    srv_err_nxt    = srv_err_r;
    ovf_nxt        = ovf_r;
    tail_time_nxt  = tail_time_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    in_tready      = 1'b0;
    mem_we         = 1'b0;
    mem_raddr      = tail_r;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ts_nxt      = in_tdata[TIME_W-1:0];
          srv_err_nxt = in_tdata[TIME_W];
          ovf_nxt     = 1'b0;
          cnt_nxt     = '0;
          if (in_tuser) begin
            mem_we   = 1'b1;
            head_nxt = advance(head_r);
            if (occ_r == OW'(FIFO_DEPTH)) begin
              // Full: the oldest entry makes room, so the fill level stays put.
              tail_nxt = advance(tail_r);
              ovf_nxt  = 1'b1;
            end else begin
              occ_nxt = occ_r + 1'b1;
            end
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        // The newest entry never leaves, so this loop always ends.
        if (excess > 0) begin
          tail_nxt  = advance(tail_r);
          occ_nxt   = occ_r - 1'b1;
          mem_raddr = advance(tail_r);
        end else begin
          tail_time_nxt = rd_time;
          cnt_nxt       = span[CNT_W] ? CNT_MAX : span[CNT_W-1:0];
          state_nxt     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          if (cnt_r > best_cnt_r) begin
            best_cnt_nxt   = cnt_r;
            best_begin_nxt = tail_time_r;
            best_end_nxt   = ts_r;
          end
          if (srv_err_r && err_r != CNT_MAX) begin
            err_nxt = err_r + 1'b1;
          end
          if (rc_r != CNT_MAX) begin
            rc_nxt = rc_r + 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, ovf_r, err_nxt, best_end_nxt, best_begin_nxt,
                           best_cnt_nxt, cnt_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== hdl/swpr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_peak_rate_macros.svh"

module swpr_checker
  import swpr_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // A result waiting for the receiver keeps its item unchanged.
  `SWPR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result item changed while stalled")

  // Each record is worked on alone, so the input closes right after an item.
  `SWPR_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "second item accepted while busy")

  // The window count can never exceed the peak reported alongside it.
  `SWPR_ASSERT_IMPL(a_peak_bound, out_tvalid, out_tdata[31:0] <= out_tdata[63:32], "window count above peak")

  // No result is shown straight after reset.
  `SWPR_ASSERT_RESET(a_reset_quiet, !rst_n, !out_tvalid, "result valid after reset")

endmodule

bind sliding_window_peak_rate swpr_checker u_swpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== tb/peak_rate_checker.sv =====
`timescale 1ns / 1ps

module peak_rate_checker
  import swpr_pkg::*;
#(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [TIME_W-1:0]     cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // timestamp[30:0], server_error[31]
  input  logic                  in_tuser,   // has_time
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // window_count[31:0], peak_count[63:32], peak_begin[94:64], peak_end[125:95],
  // error_count[157:126], overflow[158], zero[159]
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    mismatches,
  output int                    pending,
  output int                    results_checked,
  output int                    overflow_results
);

  typedef struct packed {
    logic [CNT_W-1:0]  window_count;
    logic [CNT_W-1:0]  peak_count;
    logic [TIME_W-1:0] peak_begin;
    logic [TIME_W-1:0] peak_end;
    logic [CNT_W-1:0]  error_count;
    logic              overflow;
  } rate_result_t;

  // Private copy of the block state.
  logic [TIME_W-1:0] stamp_ring [DEPTH];
  logic [CNT_W-1:0]  number_ring [DEPTH];
  int unsigned       ring_head;
  int unsigned       ring_tail;
  int unsigned       ring_fill;
  logic [CNT_W-1:0]  record_num;
  logic [CNT_W-1:0]  best_rate;
  logic [TIME_W-1:0] best_from;
  logic [TIME_W-1:0] best_to;
  logic [CNT_W-1:0]  error_total;
  logic [TIME_W-1:0] window_len;

  rate_result_t expected_rates [$];

  function automatic rate_result_t predict_record(input logic has_ts,
                                                  input logic [TIME_W-1:0] stamp,
                                                  input logic srv_err);
    rate_result_t r;
    logic [63:0]  span;
    r = '0;
    if (has_ts) begin
      if (ring_fill >= DEPTH) begin
        ring_tail = (ring_tail + 1) % DEPTH;
        ring_fill--;
        r.overflow = 1'b1;
      end
      stamp_ring[ring_head]  = stamp;
      number_ring[ring_head] = record_num;
      ring_head = (ring_head + 1) % DEPTH;
      ring_fill++;
      // An entry newer than the new stamp gives a negative distance and stays.
      while (ring_fill > 0 &&
             longint'(stamp) - longint'(stamp_ring[ring_tail]) > longint'(window_len)) begin
        ring_tail = (ring_tail + 1) % DEPTH;
        ring_fill--;
      end
      span = {32'd0, record_num} - {32'd0, number_ring[ring_tail]} + 64'd1;
      r.window_count = (span > {32'd0, CNT_MAX}) ? CNT_MAX : span[CNT_W-1:0];
      if (r.window_count > best_rate) begin
        best_rate = r.window_count;
        best_from = stamp_ring[ring_tail];
        best_to   = stamp;
      end
    end
    if (srv_err && error_total != CNT_MAX)
      error_total++;
    if (record_num != CNT_MAX)
      record_num++;
    r.peak_count  = best_rate;
    r.peak_begin  = best_from;
    r.peak_end    = best_to;
    r.error_count = error_total;
    return r;
  endfunction

  task automatic check_field(input string fname, input logic [CNT_W-1:0] want,
                             input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endtask

  initial begin
    mismatches       = 0;
    pending          = 0;
    results_checked  = 0;
    overflow_results = 0;
  end

  always @(posedge clk) begin
    rate_result_t want;
    if (!rst_n) begin
      ring_head   = 0;
      ring_tail   = 0;
      ring_fill   = 0;
      record_num  = '0;
      best_rate   = '0;
      best_from   = '0;
      best_to     = '0;
      error_total = '0;
      window_len  = WINDOW_RESET;
      expected_rates.delete();
    end else begin
      if (cfg_we)
        window_len = cfg_wdata;
      if (out_tvalid && out_tready) begin
        if (expected_rates.size() == 0) begin
          $error("result item arrived with no record outstanding");
          mismatches++;
        end else begin
          want = expected_rates.pop_front();
          check_field("window_count", want.window_count, out_tdata[31:0]);
          check_field("peak_count", want.peak_count, out_tdata[63:32]);
          check_field("peak_begin", CNT_W'(want.peak_begin), CNT_W'(out_tdata[94:64]));
          check_field("peak_end", CNT_W'(want.peak_end), CNT_W'(out_tdata[125:95]));
          check_field("error_count", want.error_count, out_tdata[157:126]);
          check_field("overflow", CNT_W'(want.overflow), CNT_W'(out_tdata[158]));
          check_field("pad", '0, CNT_W'(out_tdata[159]));
          results_checked++;
          if (want.overflow)
            overflow_results++;
        end
      end
      if (in_tvalid && in_tready)
        expected_rates.push_back(predict_record(in_tuser, in_tdata[TIME_W-1:0],
                                                in_tdata[IN_DATA_W-1]));
    end
    pending = expected_rates.size();
  end

endmodule

// ===== tb/tb_sliding_window_peak_rate.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_peak_rate;
  import swpr_pkg::*;

  localparam int    STUCK_LIMIT = 4000;
  localparam longint STAMP_MAX  = 64'h7FFF_FFFF;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [TIME_W-1:0]     cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // timestamp[30:0], server_error[31]
  logic                  in_tuser = 1'b0; // has_time
  logic                  out_tvalid;
  logic                  out_tready = 1'b1;
  // window_count[31:0], peak_count[63:32], peak_begin[94:64], peak_end[125:95],
  // error_count[157:126], overflow[158], zero[159]
  logic [OUT_DATA_W-1:0] out_tdata;

  int     mismatches;
  int     pending;
  int     results_checked;
  int     overflow_results;
  logic   quiet = 1'b0;
  int     stall_left = 0;
  int     stuck_cycles = 0;
  int     records_sent = 0;
  int     windows_used = 0;
  longint log_clock = 0;

  always #4 clk = ~clk;

  sliding_window_peak_rate u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  peak_rate_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .mismatches       (mismatches),
    .pending          (pending),
    .results_checked  (results_checked),
    .overflow_results (overflow_results)
  );

  // Receiver back-pressure in random bursts, switched off while quiet is set.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 5);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("tb_sliding_window_peak_rate: errors");
        $finish;
      end
    end
  end

  task automatic send_record(input logic has_ts, input logic [TIME_W-1:0] stamp,
                             input logic srv_err);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= has_ts;
    in_tdata  <= {srv_err, stamp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    records_sent++;
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_window(input logic [TIME_W-1:0] secs);
    wait_for_drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= secs;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    windows_used++;
  endtask

  // Mostly a slowly advancing clock, with untimed records, late records and jumps mixed in.
  task automatic send_random(input int count, input int step_max, input int untimed_pct,
                             input int late_pct, input int jump_pct);
    int                pick;
    int                lag;
    logic              has_ts;
    logic [TIME_W-1:0] stamp;
    for (int i = 0; i < count; i++) begin
      pick   = $urandom_range(0, 99);
      has_ts = 1'b1;
      if (pick < untimed_pct) begin
        has_ts = 1'b0;
        stamp  = TIME_W'($urandom);
      end else if (pick < untimed_pct + late_pct) begin
        lag   = $urandom_range(1, 100);
        stamp = (log_clock > lag) ? TIME_W'(log_clock - lag) : '0;
      end else begin
        if (pick < untimed_pct + late_pct + jump_pct) begin
          if ($urandom_range(0, 1) == 1)
            log_clock = longint'($urandom) & STAMP_MAX;
          else
            log_clock += $urandom_range(100, 5000);
        end else begin
          log_clock += $urandom_range(0, step_max);
        end
        if (log_clock > STAMP_MAX)
          log_clock = STAMP_MAX;
        stamp = TIME_W'(log_clock);
      end
      send_record(has_ts, stamp, $urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed records under the reset window of sixty seconds.
    send_record(1'b0, '1, 1'b1);
    send_record(1'b1, '0, 1'b0);
    send_record(1'b1, '0, 1'b1);
    send_record(1'b1, TIME_W'(60), 1'b0);
    send_record(1'b1, TIME_W'(61), 1'b0);
    send_record(1'b1, TIME_W'(30), 1'b1);
    send_record(1'b0, TIME_W'(12345), 1'b1);
    send_record(1'b1, '1, 1'b1);
    send_record(1'b1, '1, 1'b0);
    send_record(1'b1, '0, 1'b1);
    set_window(TIME_W'(60));
    send_record(1'b1, TIME_W'(200), 1'b0);
    // A zero window drops records from earlier seconds; those with the same or a later stamp stay.
    set_window('0);
    send_record(1'b1, TIME_W'(100), 1'b0);
    send_record(1'b1, TIME_W'(100), 1'b1);
    send_record(1'b1, TIME_W'(101), 1'b0);
    send_record(1'b1, TIME_W'(99), 1'b0);
    set_window('1);
    send_record(1'b1, '0, 1'b0);
    send_record(1'b1, '1, 1'b1);
    send_record(1'b0, '0, 1'b0);
    send_record(1'b1, TIME_W'(7), 1'b0);

    set_window(TIME_W'($urandom_range(1, 30)));
    log_clock = $urandom_range(0, 1000000);
    send_random(150, 3, 10, 5, 2);
    wait_for_drain();
    send_random(150, 3, 10, 5, 2);

    // A huge window with a slow clock keeps the FIFO full.
    set_window('1);
    log_clock = $urandom_range(0, 1000000);
    send_random(350, 1, 5, 2, 0);

    // The FIFO fills up, then large forward jumps drop all but the newest entry in one record.
    set_window(TIME_W'(1000));
    log_clock = $urandom_range(0, 1000000);
    send_random(300, 2, 5, 3, 1);

    set_window(TIME_W'(1));
    send_random(250, 2, 10, 5, 2);

    set_window(TIME_W'($urandom));
    send_random(250, 1000, 10, 10, 30);

    set_window(TIME_W'(10));
    quiet <= 1'b1;
    send_random(200, 3, 10, 5, 2);

    wait_for_drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d records under %0d window settings; %0d results checked.",
             records_sent, windows_used, results_checked);
    $display("%0d results reported a dropped entry on a full FIFO.", overflow_results);
    if (mismatches == 0) begin
      $display("tb_sliding_window_peak_rate: clean");
    end else begin
      $display("tb_sliding_window_peak_rate: errors");
    end
    $finish;
  end

endmodule
